// ===== rtl/content_type_header_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef CONTENT_TYPE_HEADER_TOKENIZER_MACROS_SVH
`define CONTENT_TYPE_HEADER_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ctht_pkg.sv =====
// Shared types, event codes and character-class functions for the tokenizer.
package ctht_pkg;

    // Event kinds on the result channel
    localparam logic [2:0] EV_TYPE   = 3'd0;
    localparam logic [2:0] EV_SUB    = 3'd1;
    localparam logic [2:0] EV_NAME   = 3'd2;
    localparam logic [2:0] EV_VALUE  = 3'd3;
    localparam logic [2:0] EV_PARAM  = 3'd4;
    localparam logic [2:0] EV_HEADER = 3'd5;

    // Bundle queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // All results caused by one input beat, in emission order:
    // optional char, optional param-complete, optional header-complete.
    typedef struct packed {
        logic       has_char;
        logic [2:0] char_kind;
        logic [7:0] char_byte;
        logic       has_param;
        logic       has_header;
    } t_bundle;

    // Space or horizontal tab
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    // Token character: printable, not a separator
    function automatic logic is_tchar(input logic [7:0] c);
        logic sep;
        sep = (c == 8'h22) || (c == 8'h28) || (c == 8'h29) || (c == 8'h2c) ||
              (c == 8'h2f) || (c == 8'h3a) || (c == 8'h3b) || (c == 8'h3c) ||
              (c == 8'h3d) || (c == 8'h3e) || (c == 8'h3f) || (c == 8'h40) ||
              (c == 8'h5b) || (c == 8'h5c) || (c == 8'h5d) || (c == 8'h7b) ||
              (c == 8'h7d);
        return (c >= 8'h21) && (c <= 8'h7e) && !sep;
    endfunction

    // ASCII A-Z to lower case, all else unchanged
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) ? (c | 8'h20) : c;
    endfunction

endpackage

// ===== rtl/content_type_header_tokenizer.sv =====
// Top level of the Content-Type header tokenizer: front end, bundle queue, back end.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_header_byte, i_final_byte
//  out     | source    | o_out_valid / i_out_stall | o_event_kind, o_out_byte, o_run_last
//
// One header byte is taken per cycle while the four-bundle queue has room.
// Each byte yields zero to three result beats; the back end sends one per cycle
// while the output is not stalled.
// A byte's first result passes through the queue, then the output register.
// Reset is synchronous, active low, and returns the parser to leading whitespace.
// o_in_stall rises only when the queue is full; output stalls back up the queue.
module content_type_header_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_header_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import ctht_pkg::*;

    t_bundle push_bundle;
    t_bundle head_bundle;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_nonempty;

    ctht_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_header_byte (i_header_byte),
        .i_final_byte  (i_final_byte),
        .i_q_full      (q_full),
        .o_stall       (o_in_stall),
        .o_push        (push),
        .o_bundle      (push_bundle)
    );

    ctht_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_bundle   (push_bundle),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_head     (head_bundle)
    );

    ctht_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (q_nonempty),
        .i_head       (head_bundle),
        .o_pop        (pop),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last)
    );

endmodule

// ===== rtl/ctht_fifo.sv =====
// Short bundle queue between the classifier and the event serializer.
`include "content_type_header_tokenizer_macros.svh"
module ctht_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ctht_pkg::t_bundle i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_nonempty,
    output ctht_pkg::t_bundle o_head
);
    import ctht_pkg::*;

    t_bundle              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]     r_count,  n_count;

    assign o_full     = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    `CTHT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")
    `CTHT_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_nonempty, "pop from empty queue")
    `CTHT_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= (FIFO_AW+1)'(FIFO_DEPTH), "count overrun")

endmodule

// ===== rtl/ctht_front.sv =====
// Front end: accepts header bytes, tracks the parse phase, builds event bundles.
module ctht_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_header_byte,
    input  logic              i_final_byte,
    input  logic              i_q_full,
    output logic              o_stall,
    output logic              o_push,
    output ctht_pkg::t_bundle o_bundle
);
    import ctht_pkg::*;

    typedef enum logic [10:0] {
        PH_LEAD      = 11'b000_0000_0001,
        PH_TYPE      = 11'b000_0000_0010,
        PH_SUB       = 11'b000_0000_0100,
        PH_AFTER     = 11'b000_0000_1000,
        PH_NAME_LEAD = 11'b000_0001_0000,
        PH_NAME      = 11'b000_0010_0000,
        PH_VAL_START = 11'b000_0100_0000,
        PH_VAL_TOK   = 11'b000_1000_0000,
        PH_QUOTED    = 11'b001_0000_0000,
        PH_ESC       = 11'b010_0000_0000,
        PH_STOP      = 11'b100_0000_0000
    } t_phase;

    t_phase  r_phase, n_phase, ph;
    t_bundle bnd;
    logic    accept;
    logic    tch;
    logic    ws;
    logic [7:0] c;

    // Phase following a finished element
    function automatic t_phase after_element(input logic [7:0] b);
        if (is_ws(b)) begin
            return PH_AFTER;
        end else if (b == 8'h3b) begin
            return PH_NAME_LEAD;
        end
        return PH_STOP;
    endfunction

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign c       = i_header_byte;
    assign tch     = is_tchar(c);
    assign ws      = is_ws(c);

    // Classify the byte against the current phase
    always_comb begin
        ph              = r_phase;
        bnd.has_char    = 1'b0;
        bnd.char_kind   = EV_TYPE;
        bnd.char_byte   = c;
        bnd.has_param   = 1'b0;
        bnd.has_header  = 1'b0;
        case (r_phase)
            PH_LEAD: begin
                if (ws) begin
                    ph = PH_LEAD;
                end else if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_TYPE;
                    bnd.char_byte = to_lower(c);
                    ph = PH_TYPE;
                end else if (c == 8'h2f) begin
                    ph = PH_SUB;
                end else begin
                    ph = after_element(c);
                end
            end
            PH_TYPE: begin
                if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_TYPE;
                    bnd.char_byte = to_lower(c);
                end else if (c == 8'h2f) begin
                    ph = PH_SUB;
                end else begin
                    ph = after_element(c);
                end
            end
            PH_SUB: begin
                if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_SUB;
                    bnd.char_byte = to_lower(c);
                end else begin
                    ph = after_element(c);
                end
            end
            PH_AFTER: begin
                ph = after_element(c);
            end
            PH_NAME_LEAD: begin
                if (ws) begin
                    ph = PH_NAME_LEAD;
                end else if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_NAME;
                    bnd.char_byte = to_lower(c);
                    ph = PH_NAME;
                end else begin
                    ph = PH_STOP;
                end
            end
            PH_NAME: begin
                if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_NAME;
                    bnd.char_byte = to_lower(c);
                end else if (c == 8'h3d) begin
                    ph = PH_VAL_START;
                end else begin
                    bnd.has_param = 1'b1;
                    ph = after_element(c);
                end
            end
            PH_VAL_START: begin
                if (c == 8'h22) begin
                    ph = PH_QUOTED;
                end else if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_VALUE;
                    ph = PH_VAL_TOK;
                end else begin
                    bnd.has_param = 1'b1;
                    ph = after_element(c);
                end
            end
            PH_VAL_TOK: begin
                if (tch) begin
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_VALUE;
                end else begin
                    bnd.has_param = 1'b1;
                    ph = after_element(c);
                end
            end
            PH_QUOTED: begin
                if (c == 8'h22) begin
                    bnd.has_param = 1'b1;
                    ph = PH_AFTER;
                end else if (c == 8'h5c && !i_final_byte) begin
                    ph = PH_ESC;
                end else begin
                    // lone backslash on the last byte is kept as-is
                    bnd.has_char  = 1'b1;
                    bnd.char_kind = EV_VALUE;
                end
            end
            PH_ESC: begin
                bnd.has_char  = 1'b1;
                bnd.char_kind = EV_VALUE;
                ph = PH_QUOTED;
            end
            default: begin
                ph = PH_STOP;
            end
        endcase

        // End of header: close an open parameter, then flag header complete
        n_phase = ph;
        if (i_final_byte) begin
            if (ph == PH_NAME || ph == PH_VAL_START || ph == PH_VAL_TOK ||
                ph == PH_QUOTED || ph == PH_ESC) begin
                bnd.has_param = 1'b1;
            end
            bnd.has_header = 1'b1;
            n_phase = PH_LEAD;
        end
    end

    assign o_bundle = bnd;
    assign o_push   = accept && (bnd.has_char || bnd.has_param || bnd.has_header);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/ctht_back.sv =====
// Back end: serializes queued bundles into single result beats.
`include "content_type_header_tokenizer_macros.svh"
module ctht_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  ctht_pkg::t_bundle i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_event_kind,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last
);
    import ctht_pkg::*;

    // bit 0 char, bit 1 param complete, bit 2 header complete
    logic [2:0] r_done, n_done;
    logic [2:0] flags, remain, sel;
    logic       load, last;
    logic       r_valid;
    logic [2:0] r_kind, n_kind;
    logic [7:0] r_byte, n_byte;
    logic       r_last;

    assign flags  = {i_head.has_header, i_head.has_param, i_head.has_char};
    assign remain = flags & ~r_done;
    assign load   = i_nonempty && (!r_valid || !i_stall);

    // Pick the earliest pending event of the head bundle
    always_comb begin
        if (remain[0]) begin
            sel    = 3'b001;
            n_kind = i_head.char_kind;
            n_byte = i_head.char_byte;
        end else if (remain[1]) begin
            sel    = 3'b010;
            n_kind = EV_PARAM;
            n_byte = '0;
        end else begin
            sel    = 3'b100;
            n_kind = EV_HEADER;
            n_byte = '0;
        end
        last   = ((remain & ~sel) == 3'b000);
        n_done = last ? 3'b000 : (r_done | sel);
    end

    assign o_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= n_done;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_last <= last;
        end
    end

    assign o_valid      = r_valid;
    assign o_event_kind = r_kind;
    assign o_out_byte   = r_byte;
    assign o_run_last   = r_last;

    `CTHT_ASSERT_IMP(a_done_subset, i_clk, i_rst_n, i_nonempty, (r_done & ~flags) == 3'b000, "done mask outside bundle")
    `CTHT_ASSERT_IMP(a_idle_clear, i_clk, i_rst_n, !i_nonempty, r_done == 3'b000, "done mask set with empty queue")
    `CTHT_ASSERT_NXT(a_pop_last, i_clk, i_rst_n, o_pop, r_valid && r_last, "pop without last beat")

endmodule

// ===== test/content_type_header_tokenizer_test.sv =====
// Self-checking testbench for the Content-Type header tokenizer.
`timescale 1ns / 1ps

module content_type_header_tokenizer_test;
    import ctht_pkg::*;

    // Parser phases, tracked by the predictor
    typedef enum logic [3:0] {
        P_LEAD, P_TYPE, P_SUBTYPE, P_AFTER, P_NAME_WAIT, P_NAME,
        P_VAL_WAIT, P_VAL_TOKEN, P_QUOTED, P_ESCAPE, P_HALTED
    } t_hdr_phase;

    typedef struct {
        logic [7:0] data;
        logic       fin;
        bit         hold;   // wait for all results to drain before offering
    } t_hdr_beat;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data;
        logic       is_last;
    } t_token_ev;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_header_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [2:0] o_event_kind;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    content_type_header_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_header_byte (i_header_byte),
        .i_final_byte  (i_final_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_kind  (o_event_kind),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last)
    );

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 60;

    t_hdr_beat  pending_bytes[$];
    t_token_ev  expected_events[$];
    t_token_ev  run_evs[$];
    logic [7:0] hdr_buf[$];
    t_hdr_phase tok_phase = P_LEAD;

    int  err_cnt = 0;
    int  headers = 0;
    int  bytes_sent = 0;
    int  beats_seen = 0;
    int  kind_count[8];
    int  burst_left = 1;
    int  gap_left = 0;
    int  hold_left = 0;
    int  next_hold_mark = 30;
    int  mode_left = 0;
    int  stall_mode = 0;
    int  idle_cycles = 0;
    logic long_hold = 1'b0;

    // ---------------------------------------------------------------- character classes
    function automatic bit is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic bit is_token_char(input logic [7:0] c);
        case (c)
            "\"", "(", ")", ",", "/", ":", ";", "<", "=", ">", "?", "@",
            "[", "\\", "]", "{", "}": return 1'b0;
            default: return (c >= 8'h21) && (c <= 8'h7e);
        endcase
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    // after type, subtype or a closed value only space or ';' may follow
    function automatic t_hdr_phase after_element(input logic [7:0] c);
        if (is_space(c))
            return P_AFTER;
        if (c == ";")
            return P_NAME_WAIT;
        return P_HALTED;
    endfunction

    // ---------------------------------------------------------------- predictor
    function automatic void add_ev(input logic [2:0] kind, input logic [7:0] data);
        t_token_ev ev;
        ev.kind = kind;
        ev.data = data;
        ev.is_last = 1'b0;
        run_evs.push_back(ev);
    endfunction

    // One accepted byte: advance the phase and queue the events it raises
    function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
        t_hdr_phase ph;
        t_token_ev  ev;
        ph = tok_phase;
        run_evs.delete();
        case (tok_phase)
            P_LEAD: begin
                if (is_space(c)) begin
                    ph = P_LEAD;
                end else if (is_token_char(c)) begin
                    add_ev(EV_TYPE, lower_case(c));
                    ph = P_TYPE;
                end else if (c == "/") begin
                    ph = P_SUBTYPE;
                end else begin
                    ph = after_element(c);
                end
            end
            P_TYPE: begin
                if (is_token_char(c))
                    add_ev(EV_TYPE, lower_case(c));
                else if (c == "/")
                    ph = P_SUBTYPE;
                else
                    ph = after_element(c);
            end
            P_SUBTYPE: begin
                if (is_token_char(c))
                    add_ev(EV_SUB, lower_case(c));
                else
                    ph = after_element(c);
            end
            P_AFTER: ph = after_element(c);
            P_NAME_WAIT: begin
                if (is_space(c)) begin
                    ph = P_NAME_WAIT;
                end else if (is_token_char(c)) begin
                    add_ev(EV_NAME, lower_case(c));
                    ph = P_NAME;
                end else begin
                    ph = P_HALTED;  // empty name
                end
            end
            P_NAME: begin
                if (is_token_char(c)) begin
                    add_ev(EV_NAME, lower_case(c));
                end else if (c == "=") begin
                    ph = P_VAL_WAIT;
                end else begin
                    add_ev(EV_PARAM, 8'h00);
                    ph = after_element(c);
                end
            end
            P_VAL_WAIT: begin
                if (c == "\"") begin
                    ph = P_QUOTED;
                end else if (is_token_char(c)) begin
                    add_ev(EV_VALUE, c);
                    ph = P_VAL_TOKEN;
                end else begin
                    add_ev(EV_PARAM, 8'h00);
                    ph = after_element(c);
                end
            end
            P_VAL_TOKEN: begin
                if (is_token_char(c)) begin
                    add_ev(EV_VALUE, c);
                end else begin
                    add_ev(EV_PARAM, 8'h00);
                    ph = after_element(c);
                end
            end
            P_QUOTED: begin
                if (c == "\"") begin
                    add_ev(EV_PARAM, 8'h00);
                    ph = P_AFTER;
                end else if (c == "\\" && !fin) begin
                    ph = P_ESCAPE;
                end else begin
                    add_ev(EV_VALUE, c);   // a backslash on the last byte stays literal
                end
            end
            P_ESCAPE: begin
                add_ev(EV_VALUE, c);
                ph = P_QUOTED;
            end
            default: ph = P_HALTED;
        endcase

        // end of header closes any open parameter
        if (fin) begin
            if (ph == P_NAME || ph == P_VAL_WAIT || ph == P_VAL_TOKEN ||
                ph == P_QUOTED || ph == P_ESCAPE)
                add_ev(EV_PARAM, 8'h00);
            add_ev(EV_HEADER, 8'h00);
            ph = P_LEAD;
        end
        tok_phase = ph;

        if (run_evs.size() > 0) begin
            ev = run_evs.pop_back();
            ev.is_last = 1'b1;
            run_evs.push_back(ev);
        end
        foreach (run_evs[i])
            expected_events.push_back(run_evs[i]);
    endfunction

    // ---------------------------------------------------------------- stimulus builders
    function automatic void add_byte(input logic [7:0] c);
        hdr_buf.push_back(c);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            hdr_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_token();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        while (!is_token_char(c))
            c = 8'($urandom_range(33, 126));
        return c;
    endfunction

    function automatic logic [7:0] rand_space();
        return $urandom_range(0, 1) ? 8'h20 : 8'h09;
    endfunction

    // any byte that neither closes nor escapes a quoted value
    function automatic logic [7:0] rand_quoted();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == "\"" || c == "\\")
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Mostly well-formed header with random content, now and then with one byte broken
    function automatic void build_header();
        int np;
        if ($urandom_range(0, 3) == 0)
            add_byte(rand_space());
        repeat ($urandom_range(0, 3)) add_byte(rand_token());
        if ($urandom_range(0, 9) != 0)
            add_byte("/");
        repeat ($urandom_range(0, 3)) add_byte(rand_token());
        np = $urandom_range(0, 2);
        repeat (np) begin
            if ($urandom_range(0, 2) == 0)
                add_byte(rand_space());
            add_byte(";");
            if ($urandom_range(0, 3) == 0)
                add_byte(rand_space());
            repeat (($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3))
                add_byte(rand_token());
            if ($urandom_range(0, 7) != 0) begin
                add_byte("=");
                if ($urandom_range(0, 2) == 0) begin
                    add_byte("\"");
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 4) == 0) begin
                            add_byte("\\");
                            add_byte(8'($urandom_range(0, 255)));
                        end else begin
                            add_byte(rand_quoted());
                        end
                    end
                    if ($urandom_range(0, 4) != 0)
                        add_byte("\"");
                end else begin
                    repeat ($urandom_range(0, 3)) add_byte(rand_token());
                end
            end
        end
        if ($urandom_range(0, 4) == 0)
            add_byte(rand_space());
        if (hdr_buf.size() > 0 && $urandom_range(0, 7) == 0)
            hdr_buf[$urandom_range(0, hdr_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    // Move the staged header to the send queue, flagging its last byte
    function automatic void flush_header(input bit drain);
        t_hdr_beat b;
        if (hdr_buf.size() == 0)
            hdr_buf.push_back(8'($urandom_range(0, 255)));
        foreach (hdr_buf[i]) begin
            b.data = hdr_buf[i];
            b.fin  = (i == hdr_buf.size() - 1);
            b.hold = drain && (i == 0);
            pending_bytes.push_back(b);
        end
        hdr_buf.delete();
        headers++;
    endfunction

    function automatic void flag_error(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
        err_cnt++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endfunction

    // ---------------------------------------------------------------- clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- input driver
    always @(posedge i_clk) begin : byte_drive
        bit offer;
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_header_byte <= 8'h00;
            i_final_byte  <= 1'b0;
            tok_phase = P_LEAD;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
        end else begin
            // beat taken at this edge
            if (i_in_valid && !o_in_stall) begin
                tokenize_byte(i_header_byte, i_final_byte);
                pending_bytes.delete(0);
                bytes_sent++;
            end
            // a stalled beat holds; otherwise pick the next one
            if (!(i_in_valid && o_in_stall)) begin
                offer = 1'b0;
                if (gap_left > 0 && !long_hold)
                    gap_left--;
                else if (pending_bytes.size() != 0)
                    offer = !pending_bytes[0].hold || expected_events.size() == 0;
                if (offer) begin
                    i_in_valid    <= 1'b1;
                    i_header_byte <= pending_bytes[0].data;
                    i_final_byte  <= pending_bytes[0].fin;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor and stall
    always @(posedge i_clk) begin : result_check
        t_token_ev want;
        logic      stall_nxt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            long_hold   <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                beats_seen++;
                kind_count[o_event_kind]++;
                if (expected_events.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: unexpected result, expected none, got kind %0h byte %0h",
                             $time, o_event_kind, o_out_byte);
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_kind !== want.kind)
                        flag_error("event kind", 8'(want.kind), 8'(o_event_kind));
                    if (o_out_byte !== want.data)
                        flag_error("out byte", want.data, o_out_byte);
                    if (o_run_last !== want.is_last)
                        flag_error("run last", 8'(want.is_last), 8'(o_run_last));
                end
            end

            // long hold-off now and then, else a random stall mode
            if (hold_left > 0) begin
                hold_left--;
                stall_nxt = 1'b1;
            end else if (beats_seen >= next_hold_mark) begin
                hold_left = LONG_HOLD - 1;
                next_hold_mark += 120;
                stall_nxt = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       stall_nxt = 1'b0;
                    1:       stall_nxt = ($urandom_range(0, 3) == 0);
                    default: stall_nxt = ($urandom_range(0, 9) < 7);
                endcase
            end
            i_out_stall <= stall_nxt;
            long_hold   <= (hold_left > 0);
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus and verdict
    initial begin : stimulus
        int base;
        bit first;

        // directed: lead space, case folding, name without value, escapes,
        // lone backslash on the last byte
        add_text(" A/Z;N;v=\"\\\"\\");
        flush_header(1'b0);
        // no type, empty value, empty name
        add_text("/~;k=;=");
        flush_header(1'b0);
        // no type before ';', header ends inside a quoted value
        add_text(";a=\"!");
        flush_header(1'b0);
        // malformed first byte, then the rest ignored
        add_byte(8'hff);
        add_byte(8'h00);
        flush_header(1'b0);

        // random headers: mostly well formed, some pure noise
        base = pending_bytes.size();
        first = 1'b1;
        while (pending_bytes.size() - base < 85) begin
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            else
                build_header();
            flush_header(first || $urandom_range(0, 9) == 0);
            first = 1'b0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d headers, %0d bytes, %0d result beats: %0d type, %0d subtype,",
                 headers, bytes_sent, beats_seen, kind_count[EV_TYPE], kind_count[EV_SUB]);
        $display("%0d name, %0d value chars, %0d params closed, %0d headers closed.",
                 kind_count[EV_NAME], kind_count[EV_VALUE], kind_count[EV_PARAM],
                 kind_count[EV_HEADER]);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
